// ===== design/barometric_sensor_compensation_assert.svh =====
// Assertion macros for the barometric sensor compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// Next-cycle implication, disabled during reset.
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

// ===== design/bsc_pkg.sv =====
// Package: types and constants of the barometric sensor compensation block.
package bsc_pkg;

    localparam int C_CFG_IDX_W = 3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_AC1_AC2 = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_AC3_AC4 = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_AC5_AC6 = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_B1_B2   = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MC_MD   = 3'd4;

    localparam int C_TDIV_W  = 27;
    localparam int C_TDVS_W  = 32;
    localparam int C_PDIV_W  = 32;
    localparam int C_PDVS_W  = 17;
    localparam int C_LATENCY = C_TDIV_W + C_PDIV_W + 11;

    localparam logic signed [31:0] C_B6_OFS = 32'sd4000;
    localparam logic signed [31:0] C_B4_OFS = 32'sd32768;
    localparam logic [31:0]        C_B7_MUL = 32'd50000;
    localparam logic signed [31:0] C_P_K1   = 32'sd3038;
    localparam logic signed [31:0] C_P_K2   = -32'sd7357;
    localparam logic signed [31:0] C_P_K3   = 32'sd3791;
    localparam logic signed [31:0] C_T_MAX  = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN  = -32'sd32768;
    localparam logic signed [31:0] C_P_MAX  = 32'sd1048575;

    typedef struct packed {
        logic signed [31:0] ac1;
        logic signed [31:0] ac2;
        logic signed [31:0] ac3;
        logic signed [31:0] ac4;
        logic signed [31:0] ac5;
        logic signed [31:0] ac6;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] mc;
        logic signed [31:0] md;
    } t_cal;

    typedef struct packed {
        logic               err;
        logic               neg;
        logic signed [31:0] x1;
        logic [15:0]        up;
    } t_tside;

    typedef struct packed {
        logic               err;
        logic               dbl;
        logic signed [15:0] t;
    } t_pside;

endpackage

// ===== design/barometric_sensor_compensation.sv =====
// Top level: calibration registers and the compensation pipeline.
//
// Channel   Direction  Handshake              Payload
// input     in         start, busy            i_raw_temperature, i_raw_pressure
// result    out        o_valid (one cycle)    o_temperature_tenths, o_pressure_pascal,
//                                             o_divide_error
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// One item per cycle; each result passes through the two bit-per-stage dividers
// (27 and 32 stages) plus 11 arithmetic stages.
// busy is always low. Synchronous reset clears valid bits and calibration.
// The receiver cannot stall; nothing in the pipeline ever waits.
`include "barometric_sensor_compensation_assert.svh"
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [15:0]            i_raw_temperature,
    input  logic [15:0]            i_raw_pressure,
    output logic                   o_valid,
    output logic signed [15:0]     o_temperature_tenths,
    output logic [19:0]            o_pressure_pascal,
    output logic                   o_divide_error,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]            i_cfg_data
);

    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    t_cal        cal;
    logic        accept;

    logic                f_vld;
    logic [C_TDIV_W-1:0] f_div;
    logic [C_TDVS_W-1:0] f_dvs;
    t_tside              f_side;
    logic [$bits(t_tside)-1:0] td_side;
    logic                td_vld;
    logic [C_TDIV_W-1:0] td_q;
    logic                c_vld;
    logic [C_PDIV_W-1:0] c_div;
    logic [C_PDVS_W-1:0] c_dvs;
    t_pside              c_side;
    logic [$bits(t_pside)-1:0] pd_side;
    logic                pd_vld;
    logic [C_PDIV_W-1:0] pd_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_AC1_AC2: r_ac1_ac2 <= i_cfg_data;
                C_REG_AC3_AC4: r_ac3_ac4 <= i_cfg_data;
                C_REG_AC5_AC6: r_ac5_ac6 <= i_cfg_data;
                C_REG_B1_B2:   r_b1_b2   <= i_cfg_data;
                C_REG_MC_MD:   r_mc_md   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cal.ac1 = {{16{r_ac1_ac2[31]}}, r_ac1_ac2[31:16]};
    assign cal.ac2 = {{16{r_ac1_ac2[15]}}, r_ac1_ac2[15:0]};
    assign cal.ac3 = {{16{r_ac3_ac4[31]}}, r_ac3_ac4[31:16]};
    assign cal.ac4 = {16'b0, r_ac3_ac4[15:0]};
    assign cal.ac5 = {16'b0, r_ac5_ac6[31:16]};
    assign cal.ac6 = {16'b0, r_ac5_ac6[15:0]};
    assign cal.b1  = {{16{r_b1_b2[31]}}, r_b1_b2[31:16]};
    assign cal.b2  = {{16{r_b1_b2[15]}}, r_b1_b2[15:0]};
    assign cal.mc  = {{16{r_mc_md[31]}}, r_mc_md[31:16]};
    assign cal.md  = {{16{r_mc_md[15]}}, r_mc_md[15:0]};

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    bsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_ut       (i_raw_temperature),
        .i_up       (i_raw_pressure),
        .i_cal      (cal),
        .o_valid    (f_vld),
        .o_dividend (f_div),
        .o_divisor  (f_dvs),
        .o_side     (f_side)
    );

    bsc_div #(.DW(C_TDIV_W), .VW(C_TDVS_W), .SW($bits(t_tside))) u_tdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_vld),
        .i_dividend (f_div),
        .i_divisor  (f_dvs),
        .i_side     (f_side),
        .o_valid    (td_vld),
        .o_quotient (td_q),
        .o_side     (td_side)
    );

    bsc_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (td_vld),
        .i_quotient (td_q),
        .i_side     (t_tside'(td_side)),
        .i_cal      (cal),
        .o_valid    (c_vld),
        .o_dividend (c_div),
        .o_divisor  (c_dvs),
        .o_side     (c_side)
    );

    bsc_div #(.DW(C_PDIV_W), .VW(C_PDVS_W), .SW($bits(t_pside))) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_vld),
        .i_dividend (c_div),
        .i_divisor  (c_dvs),
        .i_side     (c_side),
        .o_valid    (pd_vld),
        .o_quotient (pd_q),
        .o_side     (pd_side)
    );

    bsc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (pd_vld),
        .i_quotient           (pd_q),
        .i_side               (t_pside'(pd_side)),
        .o_valid              (o_valid),
        .o_temperature_tenths (o_temperature_tenths),
        .o_pressure_pascal    (o_pressure_pascal),
        .o_divide_error       (o_divide_error)
    );

    `BSC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_divide_error,
        o_temperature_tenths == 16'sd0 && o_pressure_pascal == 20'd0)
    `BSC_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(start, C_LATENCY))
    `BSC_ASSERT_IMP(a_reset_clears, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

endmodule

// ===== design/bsc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsc_div
    import bsc_pkg::*;
#(
    parameter int DW = 32,
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quotient,
    output logic [SW-1:0] o_side
);

    logic [VW-1:0] r_rem  [DW];
    logic [DW-1:0] r_word [DW];
    logic [VW-1:0] r_dvs  [DW];
    logic [SW-1:0] r_side [DW];
    logic          r_vld  [DW];

    for (genvar g = 0; g < DW; g++) begin : g_stage
        logic [VW-1:0] rem_in;
        logic [DW-1:0] word_in;
        logic [VW-1:0] dvs_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;
        logic [VW-1:0] n_rem;
        logic [DW-1:0] n_word;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign word_in = i_dividend;
            assign dvs_in  = i_divisor;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign word_in = r_word[g-1];
            assign dvs_in  = r_dvs[g-1];
            assign side_in = r_side[g-1];
            assign vld_in  = r_vld[g-1];
        end

        assign trial  = {rem_in, word_in[DW-1]};
        assign diff   = trial - {1'b0, dvs_in};
        assign ge     = trial >= {1'b0, dvs_in};
        assign n_rem  = ge ? diff[VW-1:0] : trial[VW-1:0];
        assign n_word = {word_in[DW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_word[g] <= n_word;
            r_dvs[g]  <= dvs_in;
            r_side[g] <= side_in;
        end
    end

    assign o_valid    = r_vld[DW-1];
    assign o_quotient = r_word[DW-1];
    assign o_side     = r_side[DW-1];

endmodule

// ===== design/bsc_front.sv =====
// Temperature front end: X1 and the operands of the temperature division.
module bsc_front
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [15:0]         i_ut,
    input  logic [15:0]         i_up,
    input  t_cal                i_cal,
    output logic                o_valid,
    output logic [C_TDIV_W-1:0] o_dividend,
    output logic [C_TDVS_W-1:0] o_divisor,
    output t_tside              o_side
);

    logic signed [31:0] diff;
    logic signed [31:0] prod;
    logic               r1_vld;
    logic signed [31:0] r1_x1;
    logic [15:0]        r1_up;
    logic signed [31:0] d;
    logic signed [31:0] num;
    logic [31:0]        num_mag;
    logic [31:0]        d_mag;
    logic               r2_vld;
    logic [C_TDIV_W-1:0] r2_num;
    logic [C_TDVS_W-1:0] r2_dvs;
    t_tside             r2_side;

    assign diff = $signed({16'b0, i_ut}) - i_cal.ac6;
    assign prod = diff * i_cal.ac5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    assign d       = r1_x1 + i_cal.md;
    assign num     = i_cal.mc <<< 11;
    assign num_mag = num[31] ? -num : num;
    assign d_mag   = d[31] ? -d : d;

    always_ff @(posedge i_clk) begin
        r1_x1        <= prod >>> 15;
        r1_up        <= i_up;
        r2_num       <= num_mag[C_TDIV_W-1:0];
        r2_dvs       <= d_mag;
        r2_side.err  <= (d == 32'sd0);
        r2_side.neg  <= num[31] ^ d[31];
        r2_side.x1   <= r1_x1;
        r2_side.up   <= r1_up;
    end

    assign o_valid    = r2_vld;
    assign o_dividend = r2_num;
    assign o_divisor  = r2_dvs;
    assign o_side     = r2_side;

endmodule

// ===== design/bsc_coef.sv =====
// Middle section: B5, temperature, B3, B4, B7 and the pressure division operands.
module bsc_coef
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [C_TDIV_W-1:0] i_quotient,
    input  t_tside              i_side,
    input  t_cal                i_cal,
    output logic                o_valid,
    output logic [C_PDIV_W-1:0] o_dividend,
    output logic [C_PDVS_W-1:0] o_divisor,
    output t_pside              o_side
);

    logic [5:0]         r_vld;
    logic signed [31:0] q32;
    logic signed [31:0] r3_b5;
    logic [15:0]        r3_up, r4_up, r5_up, r6_up, r7_up;
    logic               r3_err, r4_err, r5_err, r6_err, r7_err;
    logic signed [15:0] r4_t, r5_t, r6_t, r7_t;
    logic signed [31:0] t_full, b6;
    logic signed [15:0] t_sat;
    logic signed [31:0] r4_sqf, r4_ac2b6, r4_ac3b6;
    logic signed [31:0] r5_sq, r5_ac2b6, r5_ac3b6;
    logic signed [31:0] r6_b2sq, r6_b1sq, r6_ac2b6, r6_ac3b6;
    logic signed [31:0] x3, n3, b3, x3p;
    logic signed [31:0] r7_b3, r7_x3p;
    logic signed [31:0] b4_full;
    logic [31:0]        b7;
    logic [C_PDIV_W-1:0] r8_div;
    logic [C_PDVS_W-1:0] r8_dvs;
    t_pside             r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    assign q32 = i_side.neg ? -$signed({5'b0, i_quotient}) : $signed({5'b0, i_quotient});

    assign t_full = (r3_b5 + 32'sd8) >>> 4;
    assign t_sat  = (t_full > C_T_MAX) ? C_T_MAX[15:0] :
                    (t_full < C_T_MIN) ? C_T_MIN[15:0] : t_full[15:0];
    assign b6     = r3_b5 - C_B6_OFS;

    assign x3  = (r6_b2sq >>> 11) + (r6_ac2b6 >>> 11);
    assign n3  = (i_cal.ac1 <<< 2) + x3 + 32'sd2;
    assign b3  = n3[31] ? ((n3 + 32'sd3) >>> 2) : (n3 >>> 2);
    assign x3p = ((r6_ac3b6 >>> 13) + (r6_b1sq >>> 16) + 32'sd2) >>> 2;

    assign b4_full = i_cal.ac4 * (r7_x3p + C_B4_OFS);
    assign b7      = ({16'b0, r7_up} - r7_b3) * C_B7_MUL;

    always_ff @(posedge i_clk) begin
        r3_b5    <= i_side.x1 + q32;
        r3_up    <= i_side.up;
        r3_err   <= i_side.err;

        r4_t     <= t_sat;
        r4_sqf   <= b6 * b6;
        r4_ac2b6 <= i_cal.ac2 * b6;
        r4_ac3b6 <= i_cal.ac3 * b6;
        r4_up    <= r3_up;
        r4_err   <= r3_err;

        r5_sq    <= r4_sqf >>> 12;
        r5_ac2b6 <= r4_ac2b6;
        r5_ac3b6 <= r4_ac3b6;
        r5_t     <= r4_t;
        r5_up    <= r4_up;
        r5_err   <= r4_err;

        r6_b2sq  <= i_cal.b2 * r5_sq;
        r6_b1sq  <= i_cal.b1 * r5_sq;
        r6_ac2b6 <= r5_ac2b6;
        r6_ac3b6 <= r5_ac3b6;
        r6_t     <= r5_t;
        r6_up    <= r5_up;
        r6_err   <= r5_err;

        r7_b3    <= b3;
        r7_x3p   <= x3p;
        r7_t     <= r6_t;
        r7_up    <= r6_up;
        r7_err   <= r6_err;

        r8_dvs       <= b4_full[31:15];
        r8_div       <= b7[31] ? b7 : {b7[30:0], 1'b0};
        r8_side.dbl  <= b7[31];
        r8_side.err  <= r7_err | (b4_full[31:15] == '0);
        r8_side.t    <= r7_t;
    end

    assign o_valid    = r_vld[5];
    assign o_dividend = r8_div;
    assign o_divisor  = r8_dvs;
    assign o_side     = r8_side;

endmodule

// ===== design/bsc_back.sv =====
// Back end: pressure correction, saturation and error forcing.
module bsc_back
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [C_PDIV_W-1:0] i_quotient,
    input  t_pside              i_side,
    output logic                o_valid,
    output logic signed [15:0]  o_temperature_tenths,
    output logic [19:0]         o_pressure_pascal,
    output logic                o_divide_error
);

    logic [2:0]         r_vld;
    logic signed [31:0] p, ph;
    logic signed [31:0] r9_p, r9_x1a, r9_x2, r10_p, r10_x1, r10_x2;
    logic signed [31:0] k2p;
    logic signed [15:0] r9_t, r10_t;
    logic               r9_err, r10_err;
    logic signed [31:0] p_new;
    logic [19:0]        p_sat;
    logic signed [15:0] r11_t;
    logic [19:0]        r11_p;
    logic               r11_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign p   = i_side.dbl ? $signed({i_quotient[30:0], 1'b0}) : $signed(i_quotient);
    assign ph  = p >>> 8;
    assign k2p = C_P_K2 * p;

    assign p_new = r10_p + ((r10_x1 + r10_x2 + C_P_K3) >>> 4);
    assign p_sat = p_new[31] ? 20'd0 : (p_new > C_P_MAX) ? C_P_MAX[19:0] : p_new[19:0];

    always_ff @(posedge i_clk) begin
        r9_p    <= p;
        r9_x1a  <= ph * ph;
        r9_x2   <= k2p >>> 16;
        r9_t    <= i_side.t;
        r9_err  <= i_side.err;

        r10_p   <= r9_p;
        r10_x1  <= (r9_x1a * C_P_K1) >>> 16;
        r10_x2  <= r9_x2;
        r10_t   <= r9_t;
        r10_err <= r9_err;

        r11_t   <= r10_err ? 16'sd0 : r10_t;
        r11_p   <= r10_err ? 20'd0 : p_sat;
        r11_err <= r10_err;
    end

    assign o_valid              = r_vld[2];
    assign o_temperature_tenths = r11_t;
    assign o_pressure_pascal    = r11_p;
    assign o_divide_error       = r11_err;

endmodule

// ===== tb/sv/barometric_sensor_compensation_tb.sv =====
// Testbench: pressure and temperature compensation checked against an internal predictor.
`timescale 1ns / 100ps
module barometric_sensor_compensation_tb
    import bsc_pkg::*;
();

    localparam int N_RANDOM    = 950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = C_LATENCY + 20;

    typedef struct {
        logic signed [15:0] temp;
        logic [19:0]        pres;
        logic               err;
    } t_reading;

    typedef struct {
        logic [15:0] ut;
        logic [15:0] up;
        logic        known;
        t_reading    res;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [15:0]            i_raw_temperature;
    logic [15:0]            i_raw_pressure;
    logic                   o_valid;
    logic signed [15:0]     o_temperature_tenths;
    logic [19:0]            o_pressure_pascal;
    logic                   o_divide_error;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]            i_cfg_data;

    logic [31:0] cal_regs [5];
    t_reading    pending_readings[$];
    int          mismatches;
    int          cycles;
    int          idle_pct;

    barometric_sensor_compensation u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic signed [31:0] quot_trunc(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        longint q;
        q = longint'(a) / longint'(b);
        return q[31:0];
    endfunction

    function automatic t_reading compensate(input logic [15:0] ut, input logic [15:0] up);
        logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, b5, b6, b3, sq, t, p, d, ph;
        logic [31:0]        b4, b7, pq;
        t_reading           r;
        ac1 = sx16(cal_regs[C_REG_AC1_AC2][31:16]);
        ac2 = sx16(cal_regs[C_REG_AC1_AC2][15:0]);
        ac3 = sx16(cal_regs[C_REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_regs[C_REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_regs[C_REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_regs[C_REG_AC5_AC6][15:0]};
        b1  = sx16(cal_regs[C_REG_B1_B2][31:16]);
        b2  = sx16(cal_regs[C_REG_B1_B2][15:0]);
        mc  = sx16(cal_regs[C_REG_MC_MD][31:16]);
        md  = sx16(cal_regs[C_REG_MC_MD][15:0]);
        r.temp = '0;
        r.pres = '0;
        r.err  = 1'b1;
        x1 = (($signed({16'd0, ut}) - ac6) * ac5) >>> 15;
        d  = x1 + md;
        if (d == 0) return r;
        x2 = quot_trunc(mc * 2048, d);
        b5 = x1 + x2;
        t  = (b5 + 8) >>> 4;
        b6 = b5 - C_B6_OFS;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = quot_trunc(ac1 * 4 + x3 + 2, 4);
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * (x3 + C_B4_OFS)) >> 15;
        if (b4 == 0) return r;
        b7 = ({16'd0, up} - b3) * C_B7_MUL;
        if (!b7[31]) pq = (b7 * 2) / b4;
        else         pq = (b7 / b4) * 2;
        p  = pq;
        ph = p >>> 8;
        x1 = ph * ph;
        x1 = (x1 * C_P_K1) >>> 16;
        x2 = (C_P_K2 * p) >>> 16;
        p  = p + ((x1 + x2 + C_P_K3) >>> 4);
        if (t > C_T_MAX) t = C_T_MAX;
        if (t < C_T_MIN) t = C_T_MIN;
        if (p < 0) p = 0;
        if (p > C_P_MAX) p = C_P_MAX;
        r.temp = t[15:0];
        r.pres = p[19:0];
        r.err  = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result t=%0d p=%0d e=%0b",
                             o_temperature_tenths, o_pressure_pascal, o_divide_error);
            end else begin
                exp_r = pending_readings.pop_front();
                if (o_temperature_tenths !== exp_r.temp || o_pressure_pascal !== exp_r.pres
                    || o_divide_error !== exp_r.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                                 exp_r.temp, exp_r.pres, exp_r.err, o_temperature_tenths,
                                 o_pressure_pascal, o_divide_error);
                end
            end
        end
    end

    // write enable stays high; the caller drops it after the last write
    task automatic write_cal(input logic [C_CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= C_REG_MC_MD) cal_regs[idx] = data;
    endtask

    // drives one item; the check side expects a result for it
    task automatic send_item(input logic [15:0] ut, input logic [15:0] up,
                             input logic known, input t_reading res);
        t_reading r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure    <= up;
        r = known ? res : compensate(ut, up);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_readings.push_back(r);
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [31:0] r0, r1, r2, r3, r4);
        write_cal(C_REG_AC1_AC2, r0);
        write_cal(C_REG_AC3_AC4, r1);
        write_cal(C_REG_AC5_AC6, r2);
        write_cal(C_REG_B1_B2,   r3);
        write_cal(C_REG_MC_MD,   r4);
        i_cfg_we <= 1'b0;
    endtask

    // typical sensor calibration with small random perturbations
    task automatic load_typical_cal();
        load_cal({16'd408 + 16'($urandom_range(63)), 16'hFE49 - 16'($urandom_range(31))},
                 {16'hC6D1, 16'd32741 + 16'($urandom_range(255))},
                 {16'd32757 - 16'($urandom_range(255)), 16'd23153 + 16'($urandom_range(255))},
                 {16'd6190, 16'd4},
                 {16'h8000, 16'd2868 - 16'($urandom_range(200))});
    endtask

    t_stim_row directed_rows[$];
    t_reading  zero_err;

    initial begin
        int        n_items;
        mismatches        = 0;
        idle_pct          = 0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure    = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        foreach (cal_regs[k]) cal_regs[k] = '0;
        zero_err = '{temp: '0, pres: '0, err: 1'b1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: B4 is zero, every reading raises the error
        directed_rows = '{
            '{16'h0000, 16'h0000, 1'b1, zero_err},
            '{16'hFFFF, 16'hFFFF, 1'b1, zero_err},
            '{16'h8000, 16'h7FFF, 1'b1, zero_err}};
        foreach (directed_rows[k])
            send_item(directed_rows[k].ut, directed_rows[k].up, 1'b1, directed_rows[k].res);
        drain_pipe();

        // zero temperature divisor: AC5 = 0 makes X1 = 0, MD = 0
        load_cal(32'h0, 32'h0000_FFFF, 32'h0000_1234, 32'h0, 32'h1234_0000);
        directed_rows = '{
            '{16'h0000, 16'h1234, 1'b1, zero_err},
            '{16'hFFFF, 16'hFFFF, 1'b1, zero_err}};
        foreach (directed_rows[k])
            send_item(directed_rows[k].ut, directed_rows[k].up, 1'b1, directed_rows[k].res);
        drain_pipe();
        write_cal(3'd7, 32'hDEAD_BEEF);
        write_cal(3'd5, 32'h1234_5678);
        i_cfg_we <= 1'b0;

        // typical calibration and extreme readings, saturation cases
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004, 32'h8000_0B34);
        directed_rows = '{
            '{16'd27898, 16'd23843, 1'b0, zero_err},
            '{16'h0000,  16'h0000,  1'b0, zero_err},
            '{16'hFFFF,  16'hFFFF,  1'b0, zero_err},
            '{16'h0000,  16'hFFFF,  1'b0, zero_err},
            '{16'hFFFF,  16'h0000,  1'b0, zero_err},
            '{16'h5555,  16'hAAAA,  1'b0, zero_err},
            '{16'hAAAA,  16'h5555,  1'b0, zero_err}};
        foreach (directed_rows[k])
            send_item(directed_rows[k].ut, directed_rows[k].up, 1'b0, directed_rows[k].res);
        drain_pipe();

        // extreme calibration words
        load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF, 32'h8000_7FFF, 32'h7FFF_8000);
        for (int k = 0; k < 6; k++)
            send_item(k[0] ? 16'hFFFF : 16'h0000, k[1] ? 16'hFFFF : 16'h0001, 1'b0, zero_err);
        drain_pipe();
        load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_0000, 32'h7FFF_8000, 32'h8000_7FFF);
        for (int k = 0; k < 4; k++)
            send_item(16'($urandom), 16'($urandom), 1'b0, zero_err);
        drain_pipe();

        // random phases: idle profile and calibration change between phases
        n_items = 0;
        for (int ph = 0; n_items < N_RANDOM; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 64;
                2: idle_pct = 0;
                default: idle_pct = 19;
            endcase
            if (ph % 3 == 2)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_typical_cal();
            for (int k = 0; k < 80 && n_items < N_RANDOM; k++) begin
                if ($urandom_range(9) < 7)
                    send_item(16'd20000 + 16'($urandom_range(16000)),
                              16'd15000 + 16'($urandom_range(30000)), 1'b0, zero_err);
                else
                    send_item(16'($urandom), 16'($urandom), 1'b0, zero_err);
                n_items++;
            end
            drain_pipe();
        end

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
